>>> sv/mvsm_pkg.sv
// Shared constants and types for the multi-voice sample mixer.
package mvsm_pkg;

  localparam int unsigned NumVoices = 32;
  localparam int unsigned VoiceW = 5;
  localparam int unsigned MemDepth = 65536;
  localparam int unsigned MemAddrW = 16;

  // Command codes
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdStop  = 2'd2;
  localparam logic [1:0] CmdWrite = 2'd3;

  // Per-voice settings held by one cell
  typedef struct packed {
    logic        active;
    logic        looped;
    logic [15:0] base;
    logic [16:0] length;
    logic [16:0] position;
    logic [16:0] volume;
    logic [15:0] pan;
  } voice_t;

  // Control broadcast from the sequencer to all cells
  typedef struct packed {
    logic              start;
    logic              stop;
    logic [VoiceW-1:0] voice;
    logic              shift;
  } cell_ctl_t;

endpackage

>>> sv/mvsm_cell.sv
// One voice cell: holds a voice and rotates it along the ring during a tick.
module mvsm_cell
  import mvsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [VoiceW-1:0] idx_i,
  input  cell_ctl_t         ctl_i,
  input  voice_t            start_val_i,
  input  voice_t            prev_i,
  output voice_t            voice_o
);

  voice_t voice_q, voice_d;

  // Load on start, clear active on stop, take neighbor on shift
  always_comb begin
    voice_d = voice_q;
    if (ctl_i.shift) begin
      voice_d = prev_i;
    end else if (ctl_i.start && ctl_i.voice == idx_i) begin
      voice_d = start_val_i;
    end else if (ctl_i.stop && ctl_i.voice == idx_i) begin
      voice_d.active = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else begin
      voice_q <= voice_d;
    end
  end

  assign voice_o = voice_q;

endmodule

>>> sv/multi_voice_sample_mixer.sv
// Top level of the multi-voice sample mixer: cell ring, sample memory and mix pipeline.
// Start, stop and sample-write commands give no output beat.
// A tick rotates the ring of 32 voice cells once, one voice per cycle; the head voice
// reads the sample memory, its gains are formed and its products are added to the
// saturating left and right accumulators in a short pipeline behind it. After the
// rotation the pipeline drains before the frame is offered; the input stays blocked
// until the frame beat is accepted and opens in the cycle after.
module multi_voice_sample_mixer
  import mvsm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: voice(5) sample_base(16) sample_length(17) volume(17) pan(16)
  //   looped(1) mem_addr(16) mem_data(8)
  input  logic [95:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata    // left_out(8) right_out(8) playing_mask(32)
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;
  localparam int unsigned Drain = 5;

  logic [1:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  logic [4:0]  f_voice;
  logic [15:0] f_base, f_pan, f_maddr;
  logic [16:0] f_len, f_vol;
  logic        f_loop;
  logic [7:0]  f_mdata;
  assign f_voice = s_axis_tdata[4:0];
  assign f_base  = s_axis_tdata[20:5];
  assign f_len   = s_axis_tdata[37:21];
  assign f_vol   = s_axis_tdata[54:38];
  assign f_pan   = s_axis_tdata[70:55];
  assign f_loop  = s_axis_tdata[71];
  assign f_maddr = s_axis_tdata[87:72];
  assign f_mdata = s_axis_tdata[95:88];

  logic in_fire;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Ring of cells
  cell_ctl_t ctl;
  voice_t    start_val;
  voice_t    cells [NumVoices];
  voice_t    head, head_upd;
  logic      rot;

  assign rot = (state_q == StRun) && (cnt_q < 6'(NumVoices));
  assign ctl.start = in_fire && s_axis_tuser == CmdStart;
  assign ctl.stop  = in_fire && s_axis_tuser == CmdStop;
  assign ctl.voice = f_voice;
  assign ctl.shift = rot;

  always_comb begin
    start_val.active   = 1'b1;
    start_val.looped   = f_loop;
    start_val.base     = f_base;
    start_val.length   = f_len;
    start_val.position = '0;
    start_val.volume   = f_vol;
    start_val.pan      = f_pan;
  end

  assign head = cells[0];

  // Advance the head voice: wrap or stop at its end, step its position
  logic head_play;
  logic [16:0] pos_use;
  always_comb begin
    head_upd  = head;
    head_play = 1'b0;
    pos_use   = head.position;
    if (head.active) begin
      if (head.position >= head.length) begin
        if (!head.looped || head.length == '0) begin
          head_upd.active = 1'b0;
        end else begin
          pos_use   = '0;
          head_play = 1'b1;
        end
      end else begin
        head_play = 1'b1;
      end
      if (head_play) head_upd.position = pos_use + 17'd1;
    end
  end

  for (genvar g = 0; g < NumVoices; g++) begin : g_cell
    voice_t prev;
    if (g == NumVoices - 1) begin : g_last
      assign prev = head_upd;
    end else begin : g_mid
      assign prev = cells[g+1];
    end
    mvsm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (VoiceW'(g)),
      .ctl_i       (ctl),
      .start_val_i (start_val),
      .prev_i      (prev),
      .voice_o     (cells[g])
    );
  end

  // Sample memory
  logic [7:0] mem [MemDepth];
  logic [7:0] rd_q;
  logic [MemAddrW-1:0] rd_addr;
  assign rd_addr = MemAddrW'({1'b0, head.base} + pos_use);
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == CmdWrite) mem[f_maddr] <= f_mdata;
    rd_q <= mem[rd_addr];
  end

  // Stage 1: gain bases alongside memory read
  logic        p1_v_q;
  logic [17:0] bl_q, br_q;
  logic [16:0] vol1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else p1_v_q <= rot && head_play;
  end
  always_ff @(posedge clk_i) begin
    vol1_q <= head.volume;
    if (head.pan[15]) begin
      bl_q <= 18'h20000 - {1'b0, head.pan, 1'b0};
      br_q <= 18'h10000;
    end else begin
      bl_q <= 18'h10000;
      br_q <= {1'b0, head.pan, 1'b0};
    end
  end

  // Stage 2: gains
  logic        p2_v_q;
  logic [18:0] gl_q, gr_q;
  logic signed [8:0] s2_q;
  logic [34:0] gl_full, gr_full;
  assign gl_full = bl_q * vol1_q;
  assign gr_full = br_q * vol1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_v_q <= 1'b0;
    else p2_v_q <= p1_v_q;
  end
  always_ff @(posedge clk_i) begin
    gl_q <= gl_full[34:16];
    gr_q <= gr_full[34:16];
    s2_q <= $signed({1'b0, rd_q}) - 9'sd128;
  end

  // Stage 3: scaled products, floor by arithmetic shift
  logic        p3_v_q;
  logic signed [28:0] pl_full, pr_full;
  logic signed [12:0] pl_q, pr_q;
  assign pl_full = s2_q * $signed({1'b0, gl_q});
  assign pr_full = s2_q * $signed({1'b0, gr_q});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_v_q <= 1'b0;
    else p3_v_q <= p2_v_q;
  end
  always_ff @(posedge clk_i) begin
    pl_q <= pl_full[28:16];
    pr_q <= pr_full[28:16];
  end

  // Stage 4: saturating accumulate
  logic [7:0] accl_q, accr_q;
  logic signed [13:0] suml, sumr;
  assign suml = $signed({6'd0, accl_q}) + pl_q;
  assign sumr = $signed({6'd0, accr_q}) + pr_q;
  function automatic logic [7:0] sat8(input logic signed [13:0] x);
    if (x < 0) return 8'd0;
    else if (x > 14'sd255) return 8'd255;
    else return x[7:0];
  endfunction
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == CmdTick) begin
      accl_q <= 8'd128;
      accr_q <= 8'd128;
    end else if (p3_v_q) begin
      accl_q <= sat8(suml);
      accr_q <= sat8(sumr);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && s_axis_tuser == CmdTick) begin
          state_d = StRun;
          cnt_d   = '0;
        end
      end
      StRun: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NumVoices + Drain - 1)) state_d = StOut;
      end
      StOut: begin
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Frame output
  logic [31:0] mask;
  for (genvar g = 0; g < NumVoices; g++) begin : g_mask
    assign mask[g] = cells[g].active;
  end
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {mask, accr_q, accl_q};

endmodule
